FILE: rtl/core/sha512_pkg.sv
// Package for the SHA-512/SHA-384 engine: round constants, initial values,
// controller command and status types. No dependencies.
`default_nettype none
package sha512_pkg;
  typedef struct packed {
    logic load_iv;
    logic push;
    logic [63:0] push_word;
    logic start_cmp;
    logic do_round;
    logic [6:0] round;
    logic finish_cmp;
  } sha512_cmd_t;

  typedef struct packed {
    logic [3:0] words_in_block;
  } sha512_stat_t;

  function automatic logic [63:0] round_const(input logic [6:0] r);
    logic [63:0] k;
    unique case (r)
      7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] init_value(input logic mode, input logic [2:0] i);
    logic [63:0] v;
    unique case ({mode, i})
      4'd0: v = 64'hcbbb9d5dc1059ed8; 4'd1: v = 64'h629a292a367cd507;
      4'd2: v = 64'h9159015a3070dd17; 4'd3: v = 64'h152fecd8f70e5939;
      4'd4: v = 64'h67332667ffc00b31; 4'd5: v = 64'h8eb44a8768581511;
      4'd6: v = 64'hdb0c2e0d64f98fa7; 4'd7: v = 64'h47b5481dbefa4fa4;
      4'd8: v = 64'h6a09e667f3bcc908; 4'd9: v = 64'hbb67ae8584caa73b;
      4'd10: v = 64'h3c6ef372fe94f82b; 4'd11: v = 64'ha54ff53a5f1d36f1;
      4'd12: v = 64'h510e527fade682d1; 4'd13: v = 64'h9b05688c2b3e6c1f;
      4'd14: v = 64'h1f83d9abfb41bd6b; default: v = 64'h5be0cd19137e2179;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/sha512_datapath.sv
// Datapath of the SHA-512/SHA-384 engine: chaining state, block buffer,
// schedule window and round logic. Depends on sha512_pkg.
`default_nettype none
module sha512_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    mode,
  input  wire sha512_pkg::sha512_cmd_t cmd,
  output sha512_pkg::sha512_stat_t     stat,
  input  wire logic [2:0]              rd_idx,
  output logic [63:0]                  rd_word
);
  import sha512_pkg::*;

  logic [63:0] h_r [8];
  logic [63:0] buf_r [16];
  logic [63:0] w_r [16];
  logic [63:0] v_r [8];
  logic [3:0]  cnt_r;

  logic [63:0] w15, w2, s0, s1, wnew, wcur, t1, t2, e, a;

  assign rd_word = h_r[rd_idx];
  assign stat.words_in_block = cnt_r;

  always_comb begin
    w15 = w_r[1];
    w2 = w_r[14];
    s0 = {w15[0], w15[63:1]} ^ {w15[7:0], w15[63:8]} ^ (w15 >> 7);
    s1 = {w2[18:0], w2[63:19]} ^ {w2[60:0], w2[63:61]} ^ (w2 >> 6);
    wnew = w_r[0] + s0 + w_r[9] + s1;
    wcur = (cmd.round < 7'd16) ? w_r[0] : wnew;
    e = v_r[4];
    a = v_r[0];
    t1 = v_r[7] + ({e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]})
       + ((e & v_r[5]) ^ (~e & v_r[6])) + round_const(cmd.round) + wcur;
    t2 = ({a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]})
       + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      buf_r[cnt_r] <= cmd.push_word;
    end
    if (cmd.start_cmp) begin
      // The sixteenth word is pushed in the same cycle, so it bypasses the buffer.
      for (int i = 0; i < 15; i++) w_r[i] <= buf_r[i];
      w_r[15] <= cmd.push_word;
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.do_round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wcur;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_iv) begin
      for (int i = 0; i < 8; i++) h_r[i] <= init_value(rst_n ? mode : 1'b1, 3'(i));
    end else if (cmd.finish_cmp) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_iv) begin
      cnt_r <= '0;
    end else if (cmd.push) begin
      cnt_r <= cnt_r + 4'd1;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/sha512_ctrl.sv
// Controller of the SHA-512/SHA-384 engine: handshakes, padding sequence,
// round counting and digest output. Depends on sha512_pkg.
`default_nettype none
module sha512_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_wdata,
  output logic                         mode,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [63:0]             in_message_word,
  input  wire logic [3:0]              in_valid_bytes,
  input  wire logic                    in_final_word,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [2:0]                   out_word_index,
  output logic                         out_last_digest_word,
  output sha512_pkg::sha512_cmd_t      cmd,
  input  wire sha512_pkg::sha512_stat_t stat
);
  import sha512_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_ROUND = 3'd1, S_FIN = 3'd2,
                         S_PAD80 = 3'd3, S_ZERO = 3'd4, S_LEN = 3'd5, S_OUT = 3'd6;

  logic [2:0]  state_r, state_nxt, ret_r, ret_nxt;
  logic [6:0]  round_r, round_nxt;
  logic [60:0] bytes_r, bytes_nxt;
  logic        mode_r;
  logic [2:0]  idx_r, idx_nxt;
  logic [3:0]  vb;
  logic [63:0] keep, padw;
  logic        len_done_r, len_done_nxt;

  assign mode = mode_r;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_word_index = idx_r;
  assign out_last_digest_word = mode_r ? (idx_r == 3'd7) : (idx_r == 3'd5);

  always_comb begin
    vb = (in_valid_bytes > 4'd8) ? 4'd8 : in_valid_bytes;
    keep = ~(64'hffffffffffffffff >> {vb[3:0], 3'b000});
    padw = (in_message_word & keep) | (64'h8000000000000000 >> {vb[3:0], 3'b000});
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    round_nxt = round_r;
    bytes_nxt = bytes_r;
    idx_nxt = idx_r;
    len_done_nxt = len_done_r;
    cmd = '0;
    cmd.round = round_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.push = 1'b1;
          if (!in_final_word) begin
            cmd.push_word = in_message_word;
            bytes_nxt = bytes_r + 61'd8;
            ret_nxt = S_IDLE;
          end else begin
            bytes_nxt = bytes_r + 61'(vb);
            len_done_nxt = 1'b0;
            if (vb == 4'd8) begin
              cmd.push_word = in_message_word;
              ret_nxt = S_PAD80;
            end else begin
              cmd.push_word = padw;
              ret_nxt = S_ZERO;
            end
          end
          if (stat.words_in_block == 4'd15) begin
            state_nxt = S_ROUND;
            round_nxt = '0;
            cmd.start_cmp = 1'b1;
          end else begin
            state_nxt = ret_nxt;
          end
        end
      end
      S_PAD80: begin
        cmd.push = 1'b1;
        cmd.push_word = 64'h8000000000000000;
        ret_nxt = S_ZERO;
        if (stat.words_in_block == 4'd15) begin
          state_nxt = S_ROUND; round_nxt = '0; cmd.start_cmp = 1'b1;
        end else begin
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        if (stat.words_in_block == 4'd14) begin
          state_nxt = S_LEN;
        end else begin
          cmd.push = 1'b1;
          if (stat.words_in_block == 4'd15) begin
            state_nxt = S_ROUND; round_nxt = '0; cmd.start_cmp = 1'b1;
          end
        end
      end
      S_LEN: begin
        cmd.push = 1'b1;
        if (stat.words_in_block == 4'd15) begin
          cmd.push_word = {bytes_r, 3'b000};
          len_done_nxt = 1'b1;
          ret_nxt = S_OUT;
          idx_nxt = '0;
          state_nxt = S_ROUND; round_nxt = '0; cmd.start_cmp = 1'b1;
        end
      end
      S_ROUND: begin
        cmd.do_round = 1'b1;
        round_nxt = round_r + 7'd1;
        if (round_r == 7'd79) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish_cmp = 1'b1;
        state_nxt = ret_r;
      end
      S_OUT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (out_last_digest_word) begin
            cmd.load_iv = 1'b1;
            bytes_nxt = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_we) begin
      cmd.load_iv = 1'b1;
      bytes_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      round_r <= '0;
      bytes_r <= '0;
      idx_r <= '0;
      mode_r <= 1'b1;
      len_done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      round_r <= round_nxt;
      bytes_r <= bytes_nxt;
      idx_r <= idx_nxt;
      len_done_r <= len_done_nxt;
      if (cfg_we) mode_r <= cfg_wdata;
    end
  end

`ifndef SYNTHESIS
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND |-> round_r < 7'd80) else $error("round out of range");
  a_out_after_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> len_done_r) else $error("digest before length block");
  a_fin_after_round: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |-> $past(state_r) == S_ROUND) else $error("bad finish");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/sha512_sha384_hash_engine_core.sv
// SHA-512/SHA-384 engine: 80 rounds per 128-byte block, one round a cycle.
// Input stalls after each sixteenth word while the rounds and the final chaining
// update run. After the final word the padding words are pushed one by one, with
// an idle step before the length word and the rounds for each padded block;
// the digest then leaves one word per cycle while out_ready is high.
// Synchronous active-low reset selects SHA-512 and loads its initial values.
`default_nettype none
module sha512_sha384_hash_engine_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_digest_mode,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_message_word,
  input  wire logic [3:0]  in_valid_bytes,
  input  wire logic        in_final_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_digest_word
);
  import sha512_pkg::*;

  sha512_cmd_t  cmd;
  sha512_stat_t stat;
  logic         mode;

  sha512_ctrl u_ctrl (
    .clk, .rst_n, .cfg_we, .cfg_wdata(cfg_digest_mode), .mode,
    .in_valid, .in_ready, .in_message_word, .in_valid_bytes, .in_final_word,
    .out_valid, .out_ready, .out_word_index, .out_last_digest_word,
    .cmd, .stat
  );

  sha512_datapath u_dp (
    .clk, .rst_n, .mode(cfg_we ? cfg_digest_mode : mode), .cmd, .stat,
    .rd_idx(out_word_index), .rd_word(out_digest_word)
  );
endmodule
`default_nettype wire

FILE: sim/tb.sv
// Testbench for the SHA-512/SHA-384 hash engine core: a queued driver, a monitor
// and a behavioral digest predictor checking every digest word in order.
// Depends on sha512_pkg and sha512_sha384_hash_engine_core.
module tb;
  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } msg_word_t;

  typedef struct {
    logic [63:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_t;

  localparam logic MODE_384 = 1'b0;
  localparam logic MODE_512 = 1'b1;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic cfg_digest_mode = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [63:0] in_message_word = '0;
  logic [3:0] in_valid_bytes = '0;
  logic in_final_word = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [63:0] out_digest_word;
  logic [2:0] out_word_index;
  logic out_last_digest_word;

  msg_word_t pending_words[$];
  digest_t expected_digests[$];
  int errors = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit stim_done = 0;

  logic [63:0] round_k[80];
  logic [63:0] iv512[8];
  logic [63:0] iv384[8];
  logic        hash_mode;
  logic [63:0] chain[8];
  logic [63:0] blk[16];
  int          blk_fill;
  logic [60:0] byte_count;

  sha512_sha384_hash_engine_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_digest_mode(cfg_digest_mode),
    .in_valid(in_valid), .in_ready(in_ready), .in_message_word(in_message_word),
    .in_valid_bytes(in_valid_bytes), .in_final_word(in_final_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_digest_word(out_digest_word),
    .out_word_index(out_word_index), .out_last_digest_word(out_last_digest_word)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic logic [63:0] rotr(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic compress();
    logic [63:0] w[16];
    logic [63:0] v[8];
    logic [63:0] x, s0, s1, t1, t2, w15, w2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        x = w[r];
      end else begin
        w15 = w[(r - 15) & 15];
        w2 = w[(r - 2) & 15];
        s0 = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
        s1 = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
        x = w[r & 15] + s0 + w[(r - 7) & 15] + s1;
        w[r & 15] = x;
      end
      t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k[r] + x;
      t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic append_word(logic [63:0] w);
    blk[blk_fill] = w;
    blk_fill++;
    if (blk_fill == 16) begin
      compress();
      blk_fill = 0;
    end
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain[i] = hash_mode ? iv512[i] : iv384[i];
    blk_fill = 0;
    byte_count = '0;
  endtask

  task automatic predict_digest(msg_word_t m);
    int nb;
    int nwords;
    logic [63:0] keep;
    digest_t d;
    if (!m.last) begin
      byte_count += 61'd8;
      append_word(m.word);
      return;
    end
    nb = (m.nbytes > 8) ? 8 : m.nbytes;
    byte_count += 61'(nb);
    if (nb == 8) begin
      append_word(m.word);
      append_word(64'h80 << 56);
    end else begin
      keep = (nb == 0) ? 64'd0 : ~64'd0 << (64 - 8 * nb);
      append_word((m.word & keep) | (64'h80 << (56 - 8 * nb)));
    end
    if (blk_fill > 14) while (blk_fill != 0) append_word('0);
    while (blk_fill < 14) append_word('0);
    append_word('0);
    append_word({byte_count, 3'b000});
    nwords = hash_mode ? 8 : 6;
    for (int i = 0; i < nwords; i++) begin
      d.word = chain[i];
      d.idx = 3'(i);
      d.last = (i == nwords - 1);
      expected_digests.push_back(d);
    end
    restart_message();
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task automatic queue_message(int len, int last_bytes);
    msg_word_t m;
    for (int i = 0; i < len; i++) begin
      m.word = {$urandom, $urandom};
      m.last = (i == len - 1);
      m.nbytes = m.last ? 4'(last_bytes) : 4'($urandom_range(0, 15));
      pending_words.push_back(m);
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_digests.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_mode(logic mode);
    wait_drained();
    cfg_we <= 1;
    cfg_digest_mode <= mode;
    @(posedge clk);
    cfg_we <= 0;
    hash_mode = mode;
    restart_message();
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_digest('{in_message_word, in_valid_bytes, in_final_word});
        idle_cycles <= 0;
      end else if (out_valid && out_ready) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 0;
        end else if (pending_words.size() != 0) begin
          in_valid <= 1;
          in_message_word <= pending_words[0].word;
          in_valid_bytes <= pending_words[0].nbytes;
          in_final_word <= pending_words[0].last;
          void'(pending_words.pop_front());
          in_gap <= rand_gap();
        end else begin
          in_valid <= 0;
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if ($urandom_range(0, 3) == 0) out_gap <= rand_gap();
      end
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    digest_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_digests.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %h", out_digest_word));
      end else begin
        e = expected_digests.pop_front();
        if (out_digest_word !== e.word)
          report_mismatch($sformatf("word %0d: got %h exp %h", e.idx, out_digest_word, e.word));
        if (out_word_index !== e.idx)
          report_mismatch($sformatf("index: got %0d exp %0d", out_word_index, e.idx));
        if (out_last_digest_word !== e.last)
          report_mismatch($sformatf("last flag at word %0d: got %b", e.idx,
                                    out_last_digest_word));
      end
    end
  end

  initial begin
    msg_word_t m;
    int total;
    for (int r = 0; r < 80; r++) round_k[r] = sha512_pkg::round_const(7'(r));
    for (int i = 0; i < 8; i++) begin
      iv384[i] = sha512_pkg::init_value(MODE_384, 3'(i));
      iv512[i] = sha512_pkg::init_value(MODE_512, 3'(i));
    end
    hash_mode = MODE_512;
    restart_message();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    queue_message(1, 0);
    queue_message(1, 3);
    queue_message(1, 8);
    queue_message(1, 15);
    m = '{64'hffff_ffff_ffff_ffff, 4'hf, 1'b0};
    pending_words.push_back(m);
    m = '{64'h0, 4'd7, 1'b1};
    pending_words.push_back(m);
    queue_message(14, 8);
    queue_message(15, 1);
    set_mode(MODE_384);
    queue_message(1, 0);
    queue_message(16, 8);
    set_mode(MODE_512);
    queue_message(2, 5);

    total = 0;
    for (int phase = 0; phase < 6; phase++) begin
      set_mode((phase % 2) ? MODE_384 : MODE_512);
      while (total < (phase + 1) * 70) begin
        automatic int len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                        : $urandom_range(1, 17);
        queue_message(len, $urandom_range(0, 15));
        total += len;
      end
    end
    wait_drained();
    stim_done = 1;
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/sha512_pkg.sv
rtl/core/sha512_datapath.sv
rtl/core/sha512_ctrl.sv
rtl/core/sha512_sha384_hash_engine_core.sv
sim/tb.sv
